@@ sv/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the page cache controller
// Geometry, request and result codes, and the front-to-back command word.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int ADDR_BITS  = 48;
  localparam int PAGE_SHIFT = 12;
  localparam int SLOTS      = 64;
  localparam int PAGE_W     = ADDR_BITS - PAGE_SHIFT;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int OFF_W      = PAGE_SHIFT;
  localparam int LEN_W      = PAGE_SHIFT + 1;
  localparam int REQ_LEN_W  = 16;
  localparam int CNT_W      = 5;
  localparam logic [LEN_W-1:0] PAGE_BYTES = LEN_W'(1) << PAGE_SHIFT;

  typedef enum logic [1:0] {
    RT_READ   = 2'd0,
    RT_WRITE  = 2'd1,
    RT_INVALL = 2'd2,
    RT_FILL   = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    RK_SEG    = 3'd0,
    RK_FETCH  = 3'd1,
    RK_DONE   = 3'd2,
    RK_ACK    = 3'd3,
    RK_REJECT = 3'd4
  } res_kind_t;

  // classified request, queued between front and back
  typedef struct packed {
    req_type_t              req_type;
    logic [ADDR_BITS-1:0]   address;
    logic [REQ_LEN_W-1:0]   length;
    logic [LEN_W-1:0]       fill;      // saturated at page size
    logic [CNT_W-1:0]       inv_pages; // pages a write covers, 0 for none
  } cmd_t;

  typedef struct packed {
    res_kind_t              kind;
    logic [PAGE_W-1:0]      page;
    logic [5:0]             slot;
    logic [OFF_W-1:0]       off;
    logic [LEN_W-1:0]       seg;
    logic [REQ_LEN_W-1:0]   done;
    logic                   last;
  } result_t;

endpackage

@@ sv/pcc_ifs.sv @@
// ----------------------------------------------------------------------------
// pcc_ifs: request and result channels
// Valid/ready channels carrying one request word or one result word.
// ----------------------------------------------------------------------------
interface pcc_in_if import pcc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [ADDR_BITS-1:0] address;
  logic [15:0]          request_length;
  logic [12:0]          fill_bytes;

  modport source (output valid, req_type, address, request_length, fill_bytes,
                  input ready);
  modport sink   (input valid, req_type, address, request_length, fill_bytes,
                  output ready);
endinterface

interface pcc_out_if import pcc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [2:0]        result_kind;
  logic [PAGE_W-1:0] page_number;
  logic [5:0]        slot_index;
  logic [11:0]       page_offset;
  logic [12:0]       segment_length;
  logic [15:0]       bytes_done;
  logic              last_result;

  modport source (output valid, result_kind, page_number, slot_index, page_offset,
                  segment_length, bytes_done, last_result, input ready);
  modport sink   (input valid, result_kind, page_number, slot_index, page_offset,
                  segment_length, bytes_done, last_result, output ready);
endinterface

@@ sv/pcc_ram.sv @@
// ----------------------------------------------------------------------------
// pcc_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle.
// ----------------------------------------------------------------------------
module pcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/pcc_front.sv @@
// ----------------------------------------------------------------------------
// pcc_front: request intake and classification
// Decodes each word, precomputes write page span, queues up to two commands.
// ----------------------------------------------------------------------------
module pcc_front import pcc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  pcc_in_if.sink in_ch,
  output logic  cmd_valid,
  output cmd_t  cmd,
  input  logic  cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       enq;
  logic [16:0] span;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rd_ptr_r];

  always_comb begin
    span = 17'(in_ch.address[OFF_W-1:0]) + 17'(in_ch.request_length) - 17'd1;
    enq.req_type = req_type_t'(in_ch.req_type);
    enq.address  = in_ch.address;
    enq.length   = in_ch.request_length;
    enq.fill     = (in_ch.fill_bytes > PAGE_BYTES) ? PAGE_BYTES : in_ch.fill_bytes;
    if (in_ch.request_length == '0) begin
      enq.inv_pages = '0;
    end else begin
      enq.inv_pages = CNT_W'(span >> PAGE_SHIFT) + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= enq;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (cmd_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

@@ sv/pcc_back.sv @@
// ----------------------------------------------------------------------------
// pcc_back: cache state and command execution
// Tag lookup, read walk, fills and invalidation; drives the result register.
// ----------------------------------------------------------------------------
module pcc_back import pcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  pcc_out_if.source  out_ch
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_FIN   = 7'b0001000,
    S_IREAD = 7'b0010000,
    S_ICMP  = 7'b0100000,
    S_ACK   = 7'b1000000
  } state_t;

  localparam int RAM_W = PAGE_W + LEN_W;

  state_t               state_r, state_nxt;
  logic                 fp_r, fp_nxt;
  logic [SLOTS-1:0]     present_r, present_nxt;
  logic [ADDR_BITS-1:0] paddr_r, paddr_nxt;
  logic [REQ_LEN_W-1:0] plen_r, plen_nxt;
  logic [REQ_LEN_W-1:0] pdone_r, pdone_nxt;
  logic [PAGE_W-1:0]    ipage_r, ipage_nxt;
  logic [CNT_W-1:0]     icnt_r, icnt_nxt;
  logic                 ovalid_r;
  result_t              ores_r, ores_nxt;
  logic                 out_load, out_free;

  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr, ram_raddr;
  logic [RAM_W-1:0]     ram_wdata, ram_rdata;

  logic [ADDR_BITS-1:0] cur;
  logic [PAGE_W-1:0]    cur_page, rd_tag;
  logic [OFF_W-1:0]     cur_off;
  logic [SLOT_W-1:0]    cur_slot, islot;
  logic [REQ_LEN_W-1:0] rest;
  logic [LEN_W-1:0]     room, want, rd_len, have, avail;
  logic                 hit, readable;

  pcc_ram #(.WIDTH(RAM_W), .DEPTH(SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur      = paddr_r + ADDR_BITS'(pdone_r);
    cur_page = cur[ADDR_BITS-1:PAGE_SHIFT];
    cur_off  = cur[OFF_W-1:0];
    cur_slot = cur_page[SLOT_W-1:0];
    islot    = ipage_r[SLOT_W-1:0];
    rest     = plen_r - pdone_r;
    room     = PAGE_BYTES - LEN_W'(cur_off);
    want     = (rest < REQ_LEN_W'(room)) ? LEN_W'(rest) : room;
    rd_tag   = ram_rdata[RAM_W-1:LEN_W];
    rd_len   = ram_rdata[LEN_W-1:0];
    hit      = present_r[cur_slot] && (rd_tag == cur_page);
    readable = LEN_W'(cur_off) < rd_len;
    have     = rd_len - LEN_W'(cur_off);
    avail    = (want < have) ? want : have;
    ram_raddr = (state_r == S_IREAD) ? islot : cur_slot;
  end

  assign out_free = !ovalid_r || out_ch.ready;

  always_comb begin
    state_nxt   = state_r;
    fp_nxt      = fp_r;
    present_nxt = present_r;
    paddr_nxt   = paddr_r;
    plen_nxt    = plen_r;
    pdone_nxt   = pdone_r;
    ipage_nxt   = ipage_r;
    icnt_nxt    = icnt_r;
    cmd_pop     = 1'b0;
    out_load    = 1'b0;
    ores_nxt    = '0;
    ores_nxt.last = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = cur_slot;
    ram_wdata   = {cur_page, cmd.fill};

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.req_type == RT_FILL) begin
            if (!fp_r) begin
              out_load      = 1'b1;
              ores_nxt.kind = RK_ACK;
            end else begin
              ram_we                = 1'b1;
              present_nxt[cur_slot] = 1'b1;
              fp_nxt                = 1'b0;
              state_nxt             = S_LOOK;
            end
          end else if (fp_r) begin
            out_load      = 1'b1;
            ores_nxt.kind = RK_REJECT;
          end else begin
            unique case (cmd.req_type)
              RT_READ: begin
                paddr_nxt = cmd.address;
                plen_nxt  = cmd.length;
                pdone_nxt = '0;
                state_nxt = S_LOOK;
              end
              RT_WRITE: begin
                if (cmd.inv_pages == '0) begin
                  out_load      = 1'b1;
                  ores_nxt.kind = RK_ACK;
                end else begin
                  ipage_nxt = cmd.address[ADDR_BITS-1:PAGE_SHIFT];
                  icnt_nxt  = cmd.inv_pages;
                  state_nxt = S_IREAD;
                end
              end
              default: begin
                present_nxt   = '0;
                out_load      = 1'b1;
                ores_nxt.kind = RK_ACK;
              end
            endcase
          end
        end
      end
      S_LOOK: begin
        if (pdone_r >= plen_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (out_free) begin
          out_load      = 1'b1;
          ores_nxt.page = cur_page;
          ores_nxt.slot = 6'(12'(cur_slot));
          ores_nxt.done = pdone_r;
          if (!hit) begin
            ores_nxt.kind = RK_FETCH;
            fp_nxt        = 1'b1;
            state_nxt     = S_IDLE;
          end else if (!readable) begin
            ores_nxt      = '0;
            ores_nxt.kind = RK_DONE;
            ores_nxt.done = pdone_r;
            ores_nxt.last = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            ores_nxt.kind = RK_SEG;
            ores_nxt.off  = cur_off;
            ores_nxt.seg  = avail;
            ores_nxt.done = pdone_r + REQ_LEN_W'(avail);
            ores_nxt.last = 1'b0;
            pdone_nxt     = pdone_r + REQ_LEN_W'(avail);
            state_nxt     = (avail < want) ? S_FIN : S_LOOK;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load      = 1'b1;
          ores_nxt.kind = RK_DONE;
          ores_nxt.done = pdone_r;
          state_nxt     = S_IDLE;
        end
      end
      S_IREAD: begin
        state_nxt = S_ICMP;
      end
      S_ICMP: begin
        if (present_r[islot] && (rd_tag == ipage_r)) begin
          present_nxt[islot] = 1'b0;
        end
        ipage_nxt = ipage_r + PAGE_W'(1);
        icnt_nxt  = icnt_r - CNT_W'(1);
        state_nxt = (icnt_r == CNT_W'(1)) ? S_ACK : S_IREAD;
      end
      S_ACK: begin
        if (out_free) begin
          out_load      = 1'b1;
          ores_nxt.kind = RK_ACK;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    paddr_r <= paddr_nxt;
    ipage_r <= ipage_nxt;
    icnt_r  <= icnt_nxt;
    if (out_load) begin
      ores_r <= ores_nxt;
    end
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fp_r      <= 1'b0;
      present_r <= '0;
      plen_r    <= '0;
      pdone_r   <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fp_r      <= fp_nxt;
      present_r <= present_nxt;
      plen_r    <= plen_nxt;
      pdone_r   <= pdone_nxt;
      if (out_load) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.result_kind    = ores_r.kind;
  assign out_ch.page_number    = ores_r.page;
  assign out_ch.slot_index     = ores_r.slot;
  assign out_ch.page_offset    = ores_r.off;
  assign out_ch.segment_length = ores_r.seg;
  assign out_ch.bytes_done     = ores_r.done;
  assign out_ch.last_result    = ores_r.last;

`ifndef SYNTHESIS
  a_fetch_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ores_nxt.kind == RK_FETCH) |=> fp_r)
    else $error("fetch issued without pending flag");
  a_done_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pdone_r <= plen_r)
    else $error("read progress past request length");
  a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ores_nxt.kind == RK_SEG) |-> (ores_nxt.seg != '0))
    else $error("empty copy segment");
  a_no_load_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten");
`endif

endmodule

@@ sv/direct_mapped_page_cache_ctrl.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_page_cache_ctrl: direct-mapped page cache tag controller
// Splits reads into per-page copy segments, issues fetches, invalidates.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request words (read, write-done invalidate, invalidate-all,
//            fill response). Taken on valid && ready; a two-entry command
//            queue sits behind it, so ready drops only when that fills.
//   out_ch : result words (segment, fetch, read done, ack, reject), held in
//            one output register; the last word of each request has
//            last_result set.
//   Timing : one request at a time in the back end. A read walks each page
//            through S_LOOK (tag RAM registered read), then S_CMP (compare).
//            The finish word comes straight from S_FIN after a short segment,
//            and through S_LOOK then S_FIN when the read ran to its full length.
//            Write invalidation walks each page through S_IREAD and S_ICMP,
//            then the ack goes out from S_ACK.
//            Ack/reject/invalidate-all words go out the cycle after dequeue.
//   Stall  : with a result waiting and out_ch.ready low, the back end holds at
//            its next result word; the front keeps taking requests till the queue is full.
//   Reset  : synchronous, active low; clears all slot present bits, the
//            pending fetch and the queue. Tag RAM content needs no clearing.
// ----------------------------------------------------------------------------
module direct_mapped_page_cache_ctrl import pcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pcc_in_if.sink    in_ch,
  pcc_out_if.source out_ch
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // intake: decode and queue
  pcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // execution: tag state, read walk, results
  pcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

@@ bench/pcc_tb_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_tb_ifs: stimulus word type for the bench
// The bench reuses the block's own channel interfaces from sv/pcc_ifs.sv;
// this file only holds the shared word type for stimulus.
// ----------------------------------------------------------------------------
package pcc_tb_pkg;
  import pcc_pkg::*;

  typedef struct packed {
    req_type_t            kind;
    logic [ADDR_BITS-1:0] addr;
    logic [15:0]          len;
    logic [12:0]          fill;
  } req_word_t;
endpackage

@@ bench/direct_mapped_page_cache_ctrl_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_page_cache_ctrl_tb: self-checking bench of the page cache
// Drives request words with random idling, predicts the result words of each
// accepted request from a behavioral copy of the slot tags, and compares
// every accepted result word in order. Includes a long receiver stall and a
// drain pause.
// ----------------------------------------------------------------------------
module direct_mapped_page_cache_ctrl_tb;
  import pcc_pkg::*;
  import pcc_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam logic [ADDR_BITS-1:0] ADDR_MASK = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pcc_in_if  in_ch ();
  pcc_out_if out_ch ();

  direct_mapped_page_cache_ctrl i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a shadow of the slot tags and the pending read.
  // --------------------------------------------------------------------------
  logic                 sh_present [SLOTS];
  logic [PAGE_W-1:0]    sh_tag     [SLOTS];
  logic [LEN_W-1:0]     sh_rdlen   [SLOTS];
  logic                 sh_fetching;
  logic [ADDR_BITS-1:0] sh_start;
  logic [15:0]          sh_len;
  logic [15:0]          sh_done;

  result_t   expected_words [$];
  req_word_t pending_reqs [$];

  int  errors = 0;
  int  idle_pct_in = 30;
  int  idle_pct_out = 30;
  int  hold_cycles = 0;
  bit  in_taken = 1'b0;
  int  quiet_cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic result_t mk(res_kind_t k, logic [PAGE_W-1:0] pg, logic [5:0] sl,
                                 logic [OFF_W-1:0] of, logic [LEN_W-1:0] sg,
                                 logic [15:0] dn, logic ls);
    result_t r;
    r.kind = k; r.page = pg; r.slot = sl; r.off = of; r.seg = sg; r.done = dn; r.last = ls;
    return r;
  endfunction

  // Walk the pending read page by page until a miss, a short page or the end.
  task automatic walk_pending_read();
    logic [ADDR_BITS-1:0] cur;
    logic [PAGE_W-1:0]    pg;
    logic [5:0]           sl;
    int unsigned          off, want, rest, avail;
    while (sh_done < sh_len) begin
      cur   = sh_start + ADDR_BITS'(sh_done);
      pg    = cur[ADDR_BITS-1:PAGE_SHIFT];
      off   = 32'(cur[OFF_W-1:0]);
      sl    = pg[5:0];
      want  = 4096 - off;
      rest  = 32'(sh_len - sh_done);
      if (rest < want) want = rest;
      if (!sh_present[sl] || sh_tag[sl] != pg) begin
        sh_fetching = 1'b1;
        expected_words.push_back(mk(RK_FETCH, pg, sl, '0, '0, sh_done, 1'b1));
        return;
      end
      if (off >= 32'(sh_rdlen[sl])) break;
      avail = 32'(sh_rdlen[sl]) - off;
      if (want < avail) avail = want;
      sh_done = sh_done + 16'(avail);
      expected_words.push_back(mk(RK_SEG, pg, sl, OFF_W'(off), LEN_W'(avail), sh_done, 1'b0));
      if (avail < want) break;
    end
    expected_words.push_back(mk(RK_DONE, '0, '0, '0, '0, sh_done, 1'b1));
  endtask

  task automatic predict_request(input req_word_t w);
    logic [ADDR_BITS-1:0] cur;
    logic [PAGE_W-1:0]    pg;
    logic [5:0]           sl;
    longint unsigned      cnt;
    if (w.kind == RT_FILL) begin
      if (!sh_fetching) begin
        expected_words.push_back(mk(RK_ACK, '0, '0, '0, '0, '0, 1'b1));
        return;
      end
      cur = sh_start + ADDR_BITS'(sh_done);
      pg  = cur[ADDR_BITS-1:PAGE_SHIFT];
      sl  = pg[5:0];
      sh_present[sl] = 1'b1;
      sh_tag[sl]     = pg;
      sh_rdlen[sl]   = (w.fill > 13'd4096) ? 13'd4096 : w.fill;
      sh_fetching    = 1'b0;
      walk_pending_read();
      return;
    end
    if (sh_fetching) begin
      expected_words.push_back(mk(RK_REJECT, '0, '0, '0, '0, '0, 1'b1));
      return;
    end
    case (w.kind)
      RT_READ: begin
        sh_start = w.addr;
        sh_len   = w.len;
        sh_done  = '0;
        walk_pending_read();
        return;
      end
      RT_WRITE: begin
        if (w.len != 0) begin
          pg  = w.addr[ADDR_BITS-1:PAGE_SHIFT];
          cnt = ((longint'(w.addr[OFF_W-1:0]) + w.len - 1) >> PAGE_SHIFT) + 1;
          for (longint unsigned i = 0; i < cnt; i++) begin
            sl = pg[5:0];
            if (sh_present[sl] && sh_tag[sl] == pg) sh_present[sl] = 1'b0;
            pg = pg + 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) sh_present[i] = 1'b0;
      end
    endcase
    expected_words.push_back(mk(RK_ACK, '0, '0, '0, '0, '0, 1'b1));
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued words at the falling edge, predicts on acceptance.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_request(pending_reqs.pop_front());
      in_taken <= 1'b1;
    end
  end

  // A word on offer stays unchanged until it is taken.
  always @(negedge clk) begin
    in_taken <= 1'b0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      in_ch.valid <= 1'b1;
    end else if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct_in) begin
      in_ch.valid          <= 1'b1;
      in_ch.req_type       <= pending_reqs[0].kind;
      in_ch.address        <= pending_reqs[0].addr;
      in_ch.request_length <= pending_reqs[0].len;
      in_ch.fill_bytes     <= pending_reqs[0].fill;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Offer changes only at the falling edge, so the word accepted at a rising
  // edge is always the head of the queue.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.address = '0;
    in_ch.request_length = '0;
    in_ch.fill_bytes = '0;
    out_ch.ready = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: random ready, compare each accepted result word.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct_out);
    end
  end

  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        report("unexpected word kind", 64'(out_ch.result_kind), 64'(0));
      end else begin
        w = expected_words.pop_front();
        if (out_ch.result_kind != w.kind)
          report("result_kind", 64'(out_ch.result_kind), 64'(w.kind));
        if (out_ch.page_number != w.page)
          report("page_number", 64'(out_ch.page_number), 64'(w.page));
        if (out_ch.slot_index != w.slot)
          report("slot_index", 64'(out_ch.slot_index), 64'(w.slot));
        if (out_ch.page_offset != w.off)
          report("page_offset", 64'(out_ch.page_offset), 64'(w.off));
        if (out_ch.segment_length != w.seg)
          report("segment_length", 64'(out_ch.segment_length), 64'(w.seg));
        if (out_ch.bytes_done != w.done)
          report("bytes_done", 64'(out_ch.bytes_done), 64'(w.done));
        if (out_ch.last_result != w.last)
          report("last_result", 64'(out_ch.last_result), 64'(w.last));
      end
    end
  end

  // Watchdog: cycles with no word accepted on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_cycles != 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL direct_mapped_page_cache_ctrl");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic req_word_t rq(req_type_t k, logic [ADDR_BITS-1:0] a,
                                   logic [15:0] l, logic [12:0] f);
    req_word_t w;
    w.kind = k; w.addr = a; w.len = l; w.fill = f;
    return w;
  endfunction

  // Addresses mostly from narrow ranges so slots hit and conflict often.
  function automatic logic [ADDR_BITS-1:0] rand_addr();
    logic [ADDR_BITS-1:0] a;
    a = ADDR_BITS'({$urandom, $urandom});
    case ($urandom_range(3))
      0: return a;
      1: return {ADDR_BITS'(a[PAGE_SHIFT+7:0])};
      2: return ADDR_MASK - ADDR_BITS'(a[13:0]);
      default: return {a[ADDR_BITS-1:PAGE_SHIFT+3], 3'b0, a[OFF_W-1:0]};
    endcase
  endfunction

  function automatic logic [15:0] rand_len();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(1, 64));
      2: return 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(1, 9000));
    endcase
  endfunction

  function automatic logic [12:0] rand_fill();
    case ($urandom_range(4))
      0: return 13'd4096;
      1: return 13'($urandom);
      2: return 13'd0;
      default: return 13'($urandom_range(0, 4096));
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_words.size() > 0) @(posedge clk);
  endtask

  task automatic wait_sent();
    while (pending_reqs.size() > 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      sh_present[i] = 1'b0;
      sh_tag[i] = '0;
      sh_rdlen[i] = '0;
    end
    sh_fetching = 1'b0;
    sh_start = '0;
    sh_len = '0;
    sh_done = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero reads, stray fill, fills of all sizes, rejects,
    // wrap past the top address, invalidations.
    pending_reqs.push_back(rq(RT_READ, '0, 16'd0, '0));
    pending_reqs.push_back(rq(RT_FILL, '0, '0, 13'h1FFF));
    pending_reqs.push_back(rq(RT_WRITE, 48'h1000, 16'd0, '0));
    pending_reqs.push_back(rq(RT_READ, 48'h0000_0000_0FF0, 16'd8192, '0));
    pending_reqs.push_back(rq(RT_READ, '0, 16'd1, '0));
    pending_reqs.push_back(rq(RT_WRITE, '0, 16'd1, '0));
    pending_reqs.push_back(rq(RT_INVALL, '0, '0, '0));
    pending_reqs.push_back(rq(RT_FILL, '0, '0, 13'h1FFF));
    pending_reqs.push_back(rq(RT_FILL, '0, '0, 13'd4096));
    pending_reqs.push_back(rq(RT_FILL, '0, '0, 13'd100));
    pending_reqs.push_back(rq(RT_READ, 48'h0000_0000_0FF0, 16'd8192, '0));
    pending_reqs.push_back(rq(RT_READ, ADDR_MASK - 48'd15, 16'hFFFF, '0));
    pending_reqs.push_back(rq(RT_FILL, '0, '0, 13'd4096));
    pending_reqs.push_back(rq(RT_FILL, '0, '0, 13'd0));
    pending_reqs.push_back(rq(RT_READ, ADDR_MASK - 48'd15, 16'd16, '0));
    pending_reqs.push_back(rq(RT_WRITE, ADDR_MASK, 16'hFFFF, '0));
    pending_reqs.push_back(rq(RT_READ, 48'h0000_0004_0123, 16'd100, '0));
    pending_reqs.push_back(rq(RT_FILL, '0, '0, 13'd0));
    pending_reqs.push_back(rq(RT_READ, 48'h0000_0004_0123, 16'd100, '0));
    pending_reqs.push_back(rq(RT_INVALL, ADDR_MASK, 16'hFFFF, 13'h1FFF));
    wait_drained();

    // Long receiver stall while requests keep coming: the queue fills.
    hold_cycles = 400;
    for (int i = 0; i < 12; i++)
      pending_reqs.push_back(rq(req_type_t'($urandom_range(3)), rand_addr(),
                                16'($urandom_range(0, 300)), rand_fill()));
    wait (hold_cycles == 0);
    wait_drained();

    // Random: mostly read/fill pairs, some writes, invalidations and noise.
    for (int n = 0; n < 35; n++) begin
      if (n == 12) begin
        idle_pct_in = 0;
        idle_pct_out = 0;
      end
      if (n == 24) begin
        idle_pct_in = 30;
        idle_pct_out = 30;
        wait_drained();
      end
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          pending_reqs.push_back(rq(RT_READ, rand_addr(), rand_len(), rand_fill()));
          // answer up to four of the fetches the read may need
          for (int k = $urandom_range(1, 4); k > 0; k--)
            pending_reqs.push_back(rq(RT_FILL, rand_addr(), rand_len(), rand_fill()));
        end
        4, 5: pending_reqs.push_back(rq(RT_WRITE, rand_addr(), rand_len(), rand_fill()));
        6: pending_reqs.push_back(rq(RT_INVALL, rand_addr(), rand_len(), rand_fill()));
        default: pending_reqs.push_back(rq(req_type_t'($urandom_range(3)), rand_addr(),
                                           rand_len(), rand_fill()));
      endcase
      if (pending_reqs.size() > 8) wait_sent();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS direct_mapped_page_cache_ctrl");
    end else begin
      $display("FAIL direct_mapped_page_cache_ctrl");
    end
    $finish;
  end

endmodule
